@@ hdl/bps_pkg.sv @@
// Shared constants, widths and a helper function of the bucketed priority stack.
package bps_pkg;

  localparam int CAPACITY  = 256;
  localparam int LEVELS    = 16;
  localparam int ELEM_BITS = 32;

  localparam int LVL_W  = 4;
  localparam int NODE_W = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ERR_W  = 2;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;

  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_PRIO  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd2;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd3;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  localparam logic REG_MAX_PRIO = 1'b0;

  typedef logic [LEVELS-1:0] level_mask_t;

  function automatic logic [LVL_W-1:0] highest(input level_mask_t v);
    logic [LVL_W-1:0] r;
    r = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (v[i]) r = LVL_W'(i);
    end
    return r;
  endfunction

endpackage

@@ hdl/bps_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module bps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/bps_cfg.sv @@
// APB-style configuration register file holding the maximum accepted priority.
module bps_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bps_pkg::CFG_AW-1:0]  paddr,
  input  logic [bps_pkg::CFG_DW-1:0]  pwdata,
  output logic [bps_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  output logic [bps_pkg::LVL_W-1:0]   max_prio
);

  logic [bps_pkg::LVL_W-1:0] max_prio_r;
  logic [bps_pkg::LVL_W-1:0] max_prio_nxt;
  logic                      wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    max_prio_nxt = max_prio_r;
    if (wr_en && paddr[2] == bps_pkg::REG_MAX_PRIO) begin
      max_prio_nxt = pwdata[bps_pkg::LVL_W-1:0];
    end
  end

  always_comb begin
    unique case (paddr[2])
      bps_pkg::REG_MAX_PRIO: prdata = bps_pkg::CFG_DW'(max_prio_r);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_prio_r <= '1;
    end else begin
      max_prio_r <= max_prio_nxt;
    end
  end

  assign max_prio = max_prio_r;

endmodule

@@ hdl/bucketed_priority_stack.sv @@
// Top level of the bucketed priority stack: sequencer, level table and node memories.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+------------------------------
//  input   | in_kind, in_elem_value, in_priority_req | start while busy is low
//  result  | out_top_value .. out_error_code         | out_valid, one cycle, no stall
//  config  | psel, penable, pwrite, paddr, pwdata    | APB write, pready always high
//
// A push passes through ST_PUSH_WR, a pop through ST_POP_UPD and ST_POP_VAL; a rejected word is answered from idle.
// The pop cost is set by the two dependent reads of the synchronous node memories.
// Reset is synchronous and empties all levels; memory contents are not cleared.
// Each result word is shown for one cycle, and busy is low in that same cycle.
module bucketed_priority_stack (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_kind,
  input  logic [bps_pkg::ELEM_BITS-1:0]  in_elem_value,
  input  logic [bps_pkg::LVL_W-1:0]      in_priority_req,
  output logic                           out_valid,
  output logic [bps_pkg::ELEM_BITS-1:0]  out_top_value,
  output logic [bps_pkg::LVL_W-1:0]      out_top_level,
  output logic [bps_pkg::CNT_W-1:0]      out_item_total,
  output logic                           out_is_empty,
  output logic [bps_pkg::ERR_W-1:0]      out_error_code,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bps_pkg::CFG_AW-1:0]     paddr,
  input  logic [bps_pkg::CFG_DW-1:0]     pwdata,
  output logic [bps_pkg::CFG_DW-1:0]     prdata,
  output logic                           pready
);

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_PUSH_WR = 2'd1;
  localparam logic [1:0] ST_POP_UPD = 2'd2;
  localparam logic [1:0] ST_POP_VAL = 2'd3;

  localparam int NW = bps_pkg::NODE_W;
  localparam int LW = bps_pkg::LVL_W;
  localparam int CW = bps_pkg::CNT_W;
  localparam int EW = bps_pkg::ELEM_BITS;

  logic [1:0]                 state_r, state_nxt;
  bps_pkg::level_mask_t       nonempty_r, nonempty_nxt;
  logic [NW-1:0]              head_r [bps_pkg::LEVELS];
  logic [NW-1:0]              free_head_r, free_head_nxt;
  logic [CW-1:0]              fresh_next_r, fresh_next_nxt;
  logic [CW-1:0]              count_r, count_nxt;
  logic [EW-1:0]              top_value_r, top_value_nxt;
  logic [LW-1:0]              top_level_r, top_level_nxt;
  logic                       top_none_r, top_none_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [bps_pkg::ERR_W-1:0]  err_r, err_nxt;
  logic [NW-1:0]              slot_r, slot_nxt;
  logic                       from_chain_r, from_chain_nxt;
  logic [EW-1:0]              elem_r, elem_nxt;
  logic [LW-1:0]              pr_r, pr_nxt;
  logic [LW-1:0]              lv_r, lv_nxt;

  logic [LW-1:0]              max_prio;
  logic                       accept;
  logic [LW-1:0]              hl;
  logic                       any;
  logic                       prio_bad;
  logic                       full;
  logic                       from_chain;
  logic [LW-1:0]              head_idx;
  logic [NW-1:0]              head_rd;
  logic                       head_we;
  logic [LW-1:0]              head_waddr;
  logic [NW-1:0]              head_wdata;
  bps_pkg::level_mask_t       mask_after;
  logic [LW-1:0]              lv2;

  logic                       link_we;
  logic [NW-1:0]              link_waddr;
  logic [NW:0]                link_wdata;
  logic [NW-1:0]              link_raddr;
  logic [NW:0]                link_rdata;
  logic                       val_we;
  logic [NW-1:0]              val_raddr;
  logic [EW-1:0]              val_rdata;

  bps_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .max_prio (max_prio)
  );

  bps_ram #(.WIDTH(NW + 1), .DEPTH(bps_pkg::CAPACITY)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  bps_ram #(.WIDTH(EW), .DEPTH(bps_pkg::CAPACITY)) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (slot_r),
    .wdata (elem_r),
    .raddr (val_raddr),
    .rdata (val_rdata)
  );

  assign busy       = (state_r != ST_IDLE);
  assign accept     = start & ~busy;
  assign hl         = bps_pkg::highest(nonempty_r);
  assign any        = |nonempty_r;
  assign prio_bad   = (in_priority_req > max_prio) || (32'(in_priority_req) >= bps_pkg::LEVELS);
  assign full       = (32'(count_r) >= bps_pkg::CAPACITY);
  assign from_chain = (fresh_next_r > count_r);
  assign mask_after = nonempty_r & ~(bps_pkg::level_mask_t'(1) << lv_r);
  assign lv2        = bps_pkg::highest(mask_after);

  always_comb begin
    unique case (state_r)
      ST_PUSH_WR: head_idx = pr_r;
      ST_POP_UPD: head_idx = lv2;
      default:    head_idx = hl;
    endcase
  end

  assign head_rd = head_r[head_idx];

  always_comb begin
    state_nxt      = state_r;
    nonempty_nxt   = nonempty_r;
    free_head_nxt  = free_head_r;
    fresh_next_nxt = fresh_next_r;
    count_nxt      = count_r;
    top_value_nxt  = top_value_r;
    top_level_nxt  = top_level_r;
    top_none_nxt   = top_none_r;
    out_valid_nxt  = 1'b0;
    err_nxt        = err_r;
    slot_nxt       = slot_r;
    from_chain_nxt = from_chain_r;
    elem_nxt       = elem_r;
    pr_nxt         = pr_r;
    lv_nxt         = lv_r;
    head_we        = 1'b0;
    head_waddr     = pr_r;
    head_wdata     = slot_r;
    link_we        = 1'b0;
    link_waddr     = slot_r;
    link_wdata     = {~nonempty_r[pr_r], head_rd};
    link_raddr     = free_head_r;
    val_we         = 1'b0;
    val_raddr      = head_rd;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          elem_nxt = in_elem_value;
          pr_nxt   = in_priority_req;
          lv_nxt   = hl;
          err_nxt  = bps_pkg::ERR_OK;
          if (in_kind == bps_pkg::KIND_PUSH) begin
            link_raddr     = free_head_r;
            from_chain_nxt = from_chain;
            slot_nxt       = from_chain ? free_head_r : fresh_next_r[NW-1:0];
            if (prio_bad) begin
              err_nxt       = bps_pkg::ERR_PRIO;
              out_valid_nxt = 1'b1;
            end else if (full) begin
              err_nxt       = bps_pkg::ERR_FULL;
              out_valid_nxt = 1'b1;
            end else begin
              state_nxt = ST_PUSH_WR;
            end
          end else begin
            link_raddr = head_rd;
            slot_nxt   = head_rd;
            if (!any) begin
              err_nxt       = bps_pkg::ERR_EMPTY;
              out_valid_nxt = 1'b1;
            end else begin
              state_nxt = ST_POP_UPD;
            end
          end
        end
      end
      ST_PUSH_WR: begin
        link_we    = 1'b1;
        link_waddr = slot_r;
        link_wdata = {~nonempty_r[pr_r], head_rd};
        val_we     = 1'b1;
        head_we    = 1'b1;
        head_waddr = pr_r;
        head_wdata = slot_r;
        nonempty_nxt[pr_r] = 1'b1;
        count_nxt  = count_r + CW'(1);
        if (from_chain_r) begin
          free_head_nxt = link_rdata[NW-1:0];
        end else begin
          fresh_next_nxt = fresh_next_r + CW'(1);
        end
        if (top_none_r || pr_r >= top_level_r) begin
          top_value_nxt = elem_r;
          top_level_nxt = pr_r;
          top_none_nxt  = 1'b0;
        end
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      ST_POP_UPD: begin
        link_we       = 1'b1;
        link_waddr    = slot_r;
        link_wdata    = {1'b0, free_head_r};
        free_head_nxt = slot_r;
        count_nxt     = count_r - CW'(1);
        if (link_rdata[NW]) begin
          nonempty_nxt  = mask_after;
          val_raddr     = head_rd;
          top_level_nxt = (|mask_after) ? lv2 : '0;
          top_none_nxt  = ~(|mask_after);
        end else begin
          head_we       = 1'b1;
          head_waddr    = lv_r;
          head_wdata    = link_rdata[NW-1:0];
          val_raddr     = link_rdata[NW-1:0];
          top_level_nxt = lv_r;
          top_none_nxt  = 1'b0;
        end
        state_nxt = ST_POP_VAL;
      end
      ST_POP_VAL: begin
        top_value_nxt = top_none_r ? '0 : val_rdata;
        out_valid_nxt = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      nonempty_r   <= '0;
      free_head_r  <= '0;
      fresh_next_r <= '0;
      count_r      <= '0;
      top_value_r  <= '0;
      top_level_r  <= '0;
      top_none_r   <= 1'b1;
      out_valid_r  <= 1'b0;
      err_r        <= bps_pkg::ERR_OK;
    end else begin
      state_r      <= state_nxt;
      nonempty_r   <= nonempty_nxt;
      free_head_r  <= free_head_nxt;
      fresh_next_r <= fresh_next_nxt;
      count_r      <= count_nxt;
      top_value_r  <= top_value_nxt;
      top_level_r  <= top_level_nxt;
      top_none_r   <= top_none_nxt;
      out_valid_r  <= out_valid_nxt;
      err_r        <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r       <= slot_nxt;
    from_chain_r <= from_chain_nxt;
    elem_r       <= elem_nxt;
    pr_r         <= pr_nxt;
    lv_r         <= lv_nxt;
    if (head_we) head_r[head_waddr] <= head_wdata;
  end

  assign out_valid      = out_valid_r;
  assign out_top_value  = top_value_r;
  assign out_top_level  = top_level_r;
  assign out_item_total = count_r;
  assign out_is_empty   = (count_r == '0);
  assign out_error_code = err_r;

endmodule

@@ verif/bps_checker.sv @@
`timescale 1ns / 1ps
// Checker for the bucketed priority stack: predicts every result word and compares it field by field.
module bps_checker
  import bps_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 busy,
  input  logic                 in_kind,
  input  logic [ELEM_BITS-1:0] in_elem_value,
  input  logic [LVL_W-1:0]     in_priority_req,
  input  logic                 out_valid,
  input  logic [ELEM_BITS-1:0] out_top_value,
  input  logic [LVL_W-1:0]     out_top_level,
  input  logic [CNT_W-1:0]     out_item_total,
  input  logic                 out_is_empty,
  input  logic [ERR_W-1:0]     out_error_code,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [CFG_AW-1:0]    paddr,
  input  logic [CFG_DW-1:0]    pwdata,
  input  logic                 pready,
  output int                   outstanding,
  output int                   fail_count
);

  localparam logic [CFG_AW-1:0] MAX_PRIO_ADDR = CFG_AW'(4 * REG_MAX_PRIO);

  typedef struct packed {
    logic [LVL_W-1:0]     level;
    logic [ELEM_BITS-1:0] value;
  } stored_elem_t;

  typedef struct packed {
    logic [ELEM_BITS-1:0] top_value;
    logic [LVL_W-1:0]     top_level;
    logic [CNT_W-1:0]     total;
    logic                 empty;
    logic [ERR_W-1:0]     err;
  } status_word_t;

  // Elements in push order; the top is the latest one of the highest level.
  stored_elem_t stored_elems[$];
  status_word_t expected_status[$];
  logic [LVL_W-1:0] max_prio;

  function automatic int top_index();
    int best;
    best = -1;
    for (int i = 0; i < stored_elems.size(); i++) begin
      if (best < 0 || stored_elems[i].level >= stored_elems[best].level) best = i;
    end
    return best;
  endfunction

  function automatic status_word_t apply_word(input logic kind,
                                              input logic [ELEM_BITS-1:0] value,
                                              input logic [LVL_W-1:0] prio);
    status_word_t w;
    int idx;
    w = '0;
    w.err = ERR_OK;
    if (kind == KIND_PUSH) begin
      if (prio > max_prio) begin
        w.err = ERR_PRIO;
      end else if (stored_elems.size() >= CAPACITY) begin
        w.err = ERR_FULL;
      end else begin
        stored_elems.push_back('{level: prio, value: value});
      end
    end else begin
      idx = top_index();
      if (idx < 0) begin
        w.err = ERR_EMPTY;
      end else begin
        stored_elems.delete(idx);
      end
    end
    idx = top_index();
    if (idx >= 0) begin
      w.top_value = stored_elems[idx].value;
      w.top_level = stored_elems[idx].level;
    end
    w.total = CNT_W'(stored_elems.size());
    w.empty = (stored_elems.size() == 0);
    return w;
  endfunction

  task automatic report(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [ELEM_BITS-1:0] got,
                             input logic [ELEM_BITS-1:0] want);
    if (got !== want) report($sformatf("%s is %0h, expected %0h", name, got, want));
  endtask

  always @(posedge clk) begin
    status_word_t want;
    if (!rst_n) begin
      stored_elems.delete();
      expected_status.delete();
      max_prio = LVL_W'(LEVELS - 1);
    end else begin
      if (out_valid) begin
        if (expected_status.size() == 0) begin
          report("result word with no word outstanding");
        end else begin
          want = expected_status.pop_front();
          check_field("top_value", out_top_value, want.top_value);
          check_field("top_level", ELEM_BITS'(out_top_level), ELEM_BITS'(want.top_level));
          check_field("item_total", ELEM_BITS'(out_item_total), ELEM_BITS'(want.total));
          check_field("is_empty", ELEM_BITS'(out_is_empty), ELEM_BITS'(want.empty));
          check_field("error_code", ELEM_BITS'(out_error_code), ELEM_BITS'(want.err));
        end
      end
      if (psel && penable && pwrite && pready && paddr == MAX_PRIO_ADDR) begin
        max_prio = pwdata[LVL_W-1:0];
      end
      if (start && !busy) begin
        expected_status.push_back(apply_word(in_kind, in_elem_value, in_priority_req));
      end
    end
    outstanding <= expected_status.size();
  end

endmodule

@@ verif/bucketed_priority_stack_test.sv @@
`timescale 1ns / 1ps
// Testbench top for the bucketed priority stack: clock, reset, stimulus, watchdog and verdict.
module bucketed_priority_stack_test;
  import bps_pkg::*;

  localparam int QUIET_LIMIT = 1000;
  localparam logic [CFG_AW-1:0] MAX_PRIO_ADDR = CFG_AW'(4 * REG_MAX_PRIO);

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 in_kind = KIND_PUSH;
  logic [ELEM_BITS-1:0] in_elem_value = '0;
  logic [LVL_W-1:0]     in_priority_req = '0;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [CFG_AW-1:0]    paddr = '0;
  logic [CFG_DW-1:0]    pwdata = '0;

  logic                 busy;
  logic                 out_valid;
  logic [ELEM_BITS-1:0] out_top_value;
  logic [LVL_W-1:0]     out_top_level;
  logic [CNT_W-1:0]     out_item_total;
  logic                 out_is_empty;
  logic [ERR_W-1:0]     out_error_code;
  logic [CFG_DW-1:0]    prdata;
  logic                 pready;

  int outstanding;
  int fail_count;
  int quiet_cycles = 0;
  logic gaps_on = 1'b1;
  logic [LVL_W-1:0] cur_max = LVL_W'(LEVELS - 1);

  always #6 clk = ~clk;

  bucketed_priority_stack dut (.*);

  bps_checker checker_i (.*);

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (psel && penable && pwrite && pready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  task automatic send_word(input logic kind, input logic [ELEM_BITS-1:0] value,
                           input logic [LVL_W-1:0] prio);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start           <= 1'b1;
    in_kind         <= kind;
    in_elem_value   <= value;
    in_priority_req <= prio;
    do @(posedge clk); while (busy);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0 || busy);
  endtask

  task automatic set_max(input logic [LVL_W-1:0] level);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MAX_PRIO_ADDR;
    pwdata  <= CFG_DW'(level);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cur_max = level;
  endtask

  function automatic logic [LVL_W-1:0] pick_level();
    if ($urandom_range(0, 4) == 0) return LVL_W'($urandom_range(0, LEVELS - 1));
    return LVL_W'($urandom_range(0, cur_max));
  endfunction

  task automatic random_words(input int count, input int push_pct);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < push_pct) begin
        send_word(KIND_PUSH, $urandom, pick_level());
      end else begin
        send_word(KIND_POP, $urandom, LVL_W'($urandom_range(0, LEVELS - 1)));
      end
    end
  endtask

  initial begin
    int maxes[8];
    int push_pcts[8];
    maxes = '{15, 0, 7, 1, 14, 16, 16, 15};
    push_pcts = '{70, 50, 60, 40, 75, 55, 65, 50};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_word(KIND_POP, 32'h0, 4'h0);
    send_word(KIND_PUSH, 32'hFFFF_FFFF, 4'hF);
    send_word(KIND_PUSH, 32'h0000_0000, 4'h0);
    send_word(KIND_PUSH, 32'hA5A5_A5A5, 4'h0);
    send_word(KIND_POP, 32'hFFFF_FFFF, 4'hF);
    send_word(KIND_PUSH, 32'h1234_5678, 4'h9);
    send_word(KIND_PUSH, 32'h5A5A_5A5A, 4'h9);
    send_word(KIND_POP, 32'h0, 4'h0);
    send_word(KIND_POP, 32'h0, 4'h0);
    send_word(KIND_POP, 32'h0, 4'h0);
    send_word(KIND_POP, 32'h0, 4'h0);
    send_word(KIND_POP, 32'h0, 4'h0);
    send_word(KIND_PUSH, 32'hDEAD_BEEF, 4'h9);
    send_word(KIND_PUSH, 32'h0000_0001, 4'h2);

    // Levels 9 and 2 stay above the lowered limit and must still be served first.
    set_max(4'h0);
    send_word(KIND_PUSH, 32'h0000_0007, 4'h0);
    send_word(KIND_PUSH, 32'h0000_0008, 4'h1);
    send_word(KIND_PUSH, 32'h0000_0009, 4'hF);
    send_word(KIND_PUSH, 32'h8000_0000, 4'h8);
    send_word(KIND_POP, 32'h0, 4'h0);
    send_word(KIND_POP, 32'h0, 4'h0);
    send_word(KIND_POP, 32'h0, 4'h0);
    send_word(KIND_POP, 32'h0, 4'h0);

    set_max(4'hF);
    for (int i = 0; i < CAPACITY + 24; i++) begin
      send_word(KIND_PUSH, $urandom, LVL_W'($urandom_range(0, LEVELS - 1)));
    end
    set_max(4'h4);
    for (int i = 0; i < 16; i++) begin
      send_word(KIND_PUSH, $urandom, LVL_W'($urandom_range(0, LEVELS - 1)));
    end
    random_words(8, 50);
    set_max(4'hF);
    for (int i = 0; i < CAPACITY + 44; i++) begin
      send_word(KIND_POP, $urandom, LVL_W'($urandom_range(0, LEVELS - 1)));
    end

    for (int r = 0; r < 8; r++) begin
      set_max(maxes[r] > 15 ? LVL_W'($urandom_range(0, LEVELS - 1)) : LVL_W'(maxes[r]));
      gaps_on = (r != 7);
      random_words(150, push_pcts[r]);
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
